// ===== rtl/okmu_pkg.sv =====
// Shared constants and codes for the online k-means update core.
`timescale 1ns / 1ps
package okmu_pkg;

  localparam int MaxClusters = 8;
  localparam int MaxDims     = 16;
  localparam int MaxPoints   = 1024;

  localparam int CountW = 11;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [1:0] ReqLoadCentroid = 2'd0;
  localparam logic [1:0] ReqSetCluster   = 2'd1;
  localparam logic [1:0] ReqFeature      = 2'd2;

  localparam logic CfgNumClusters = 1'b0;
  localparam logic CfgNumDims     = 1'b1;

  localparam logic [3:0] NumClustersReset = 4'd3;
  localparam logic [4:0] NumDimsReset     = 5'd2;

endpackage

// ===== rtl/online_kmeans_update_core.sv =====
// Online k-means assignment and centroid update engine, top level.
//
// Input words arrive on a valid/ready channel. Load words write one centroid
// element or a point's initial cluster. Feature words fill a point buffer; the
// word marked last starts the nearest-centroid search and, when the point
// changes cluster, the update of both affected centroids.
// The search reads the centroid memory one element at a time; for each element
// it reads it, forms the absolute difference, squares it and accumulates it. A
// move adds a walk over num_dims elements of two centroids, each element worked
// out by the bit-serial divider (one quotient bit per cycle, 33 bits).
// Only one word is worked on at a time; the block accepts a new word as soon
// as the previous one has finished, even while its result word still waits.
// If the receiver stalls, the result is held in the output register and the
// next result waits until that word is taken.
// Reset clears the control state and member counts and sets num_clusters to 3
// and num_dims to 2; the memories are not cleared.
// Configuration is a plain write port taken in any cycle.
`timescale 1ns / 1ps
module online_kmeans_update_core #(
  parameter int MAX_CLUSTERS = okmu_pkg::MaxClusters,
  parameter int MAX_DIMS     = okmu_pkg::MaxDims,
  parameter int MAX_POINTS   = okmu_pkg::MaxPoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  point_index_i,
  input  logic [2:0]  cluster_index_i,
  input  logic [3:0]  dim_index_i,
  input  logic signed [31:0] value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  new_cluster_o,
  output logic [2:0]  old_cluster_o,
  output logic        moved_o,
  output logic [63:0] min_distance_o
);
  import okmu_pkg::*;

  localparam int CW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PA  = $clog2(MAX_POINTS);
  localparam int CD  = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW  = (CD > 1) ? $clog2(CD) : 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DRD  = 11'b00000000010,
    S_DSQ  = 11'b00000000100,
    S_DMUL = 11'b00000001000,
    S_DACC = 11'b00000010000,
    S_PCHK = 11'b00000100000,
    S_UPD  = 11'b00001000000,
    S_URD  = 11'b00010000000,
    S_UINI = 11'b00100000000,
    S_UDIV = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] num_clusters_q;
  logic [4:0] num_dims_q;

  logic [31:0] cmem [CD];
  logic [31:0] cdata_q;
  logic [AW-1:0] craddr, cwaddr;
  logic [31:0] cwdata;
  logic cwe;

  logic [CW-1:0] pmem [MAX_POINTS];
  logic [CW-1:0] pdata_q;
  logic pwe;

  logic [31:0] pbuf_q [MAX_DIMS];
  logic [CountW-1:0] count_q [MAX_CLUSTERS];

  logic [9:0] pt_q;
  logic [16:0] pt_ext;
  logic [CW-1:0] c_q, best_q, oldc_q, walk_c;
  logic [DIW-1:0] d_q;
  logic phase_q, moved_q;
  logic [32:0] ad_q;
  logic [63:0] sq_q, acc_q, mind_q;
  logic signed [31:0] mu_q;
  logic neg_q;
  logic [10:0] rem_q;
  logic [32:0] quot_q;
  logic [5:0] iter_q;

  logic [6:0] nc_eff;
  logic [8:0] nd_eff;
  logic [CW-1:0] nc_m1;
  logic [DIW-1:0] nd_m1;

  logic in_fire;
  logic [64:0] sum65;
  logic [63:0] sum;
  logic [CountW-1:0] divisor;
  logic signed [32:0] diff;
  logic [11:0] shifted;
  logic signed [34:0] qs, res;
  logic [31:0] res_sat;
  logic [7:0] dim_ext;
  logic [7:0] cl_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pt_ext     = 17'(pt_q);
  assign dim_ext    = 8'(dim_index_i);
  assign cl_ext     = 8'(cluster_index_i);

  assign nc_eff = (num_clusters_q == 4'd0) ? 7'd1 :
                  (32'(num_clusters_q) > MAX_CLUSTERS) ? 7'(MAX_CLUSTERS) : 7'(num_clusters_q);
  assign nd_eff = (num_dims_q == 5'd0) ? 9'd1 :
                  (32'(num_dims_q) > MAX_DIMS) ? 9'(MAX_DIMS) : 9'(num_dims_q);
  assign nc_m1 = CW'(nc_eff - 7'd1);
  assign nd_m1 = DIW'(nd_eff - 9'd1);

  assign walk_c  = phase_q ? oldc_q : best_q;
  assign divisor = count_q[walk_c];

  assign sum65 = {1'b0, acc_q} + {1'b0, sq_q};
  assign sum   = sum65[64] ? '1 : sum65[63:0];

  assign diff    = 33'(signed'(pbuf_q[d_q])) - 33'(signed'(cdata_q));
  assign shifted = {rem_q, quot_q[32]};
  assign qs      = neg_q ? -35'(quot_q) : 35'(quot_q);
  assign res     = phase_q ? (35'(mu_q) - qs) : (35'(mu_q) + qs);
  assign res_sat = (res > 35'sd2147483647) ? 32'h7fffffff :
                   (res < -35'sd2147483648) ? 32'h80000000 : res[31:0];

  always_comb begin
    craddr = AW'(c_q) * AW'(MAX_DIMS) + AW'(d_q);
    if (state_q == S_URD || state_q == S_UINI || state_q == S_UDIV) begin
      craddr = AW'(walk_c) * AW'(MAX_DIMS) + AW'(d_q);
    end
  end

  always_comb begin
    cwe    = 1'b0;
    cwaddr = AW'(walk_c) * AW'(MAX_DIMS) + AW'(d_q);
    cwdata = res_sat;
    if (state_q == S_IDLE) begin
      cwaddr = AW'(cluster_index_i) * AW'(MAX_DIMS) + AW'(dim_index_i);
      cwdata = value_i;
      cwe    = in_fire && req_type_i == ReqLoadCentroid &&
               32'(cl_ext) < MAX_CLUSTERS && 32'(dim_ext) < MAX_DIMS;
    end else if (state_q == S_UINI && phase_q && divisor == '0) begin
      cwe    = 1'b1;
      cwdata = '0;
    end else if (state_q == S_UDIV && iter_q == 6'd0) begin
      cwe = 1'b1;
    end
  end

  assign pwe = in_fire && req_type_i == ReqSetCluster &&
               32'(point_index_i) < MAX_POINTS && 32'(cl_ext) < MAX_CLUSTERS;

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cmem[cwaddr] <= cwdata;
    end
    cdata_q <= cmem[craddr];
  end

  // A moved point takes its new cluster while the counts are updated.
  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[PA'(point_index_i)] <= CW'(cluster_index_i);
    end else if (state_q == S_UPD) begin
      pmem[pt_ext[PA-1:0]] <= best_q;
    end
    pdata_q <= pmem[pt_ext[PA-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= NumClustersReset;
      num_dims_q     <= NumDimsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumClusters: num_clusters_q <= cfg_data_i[3:0];
        CfgNumDims:     num_dims_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        count_q[i] <= '0;
      end
    end else if (pwe) begin
      if (count_q[CW'(cluster_index_i)] != CountMax) begin
        count_q[CW'(cluster_index_i)] <= count_q[CW'(cluster_index_i)] + 1'b1;
      end
    end else if (state_q == S_UPD) begin
      if (count_q[best_q] != CountMax) begin
        count_q[best_q] <= count_q[best_q] + 1'b1;
      end
      if (count_q[oldc_q] != '0) begin
        count_q[oldc_q] <= count_q[oldc_q] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && req_type_i == ReqFeature && 32'(dim_ext) < MAX_DIMS) begin
      pbuf_q[dim_ext[DIW-1:0]] <= value_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire && req_type_i == ReqFeature && last_i) state_d = S_DRD;
      S_DRD:  state_d = S_DSQ;
      S_DSQ:  state_d = S_DMUL;
      S_DMUL: state_d = S_DACC;
      S_DACC: begin
        if (d_q == nd_m1 && c_q == nc_m1) begin
          state_d = S_PCHK;
        end else begin
          state_d = S_DRD;
        end
      end
      S_PCHK: begin
        if (32'(pt_ext) >= MAX_POINTS || pdata_q == best_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD:  state_d = S_URD;
      S_URD:  state_d = S_UINI;
      S_UINI: begin
        if (phase_q && divisor == '0) begin
          state_d = (d_q == nd_m1) ? S_DONE : S_URD;
        end else begin
          state_d = S_UDIV;
        end
      end
      S_UDIV: begin
        if (iter_q == 6'd0) begin
          state_d = (d_q == nd_m1 && phase_q) ? S_DONE : S_URD;
        end
      end
      S_DONE: if (!out_valid_o || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the search and the centroid walk.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pt_q  <= point_index_i;
        c_q   <= '0;
        d_q   <= '0;
        acc_q <= '0;
      end
      S_DSQ: begin
        ad_q <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      S_DMUL: begin
        sq_q <= ad_q[32] ? '1 : 64'(ad_q[31:0]) * 64'(ad_q[31:0]);
      end
      S_DACC: begin
        if (d_q == nd_m1) begin
          if (c_q == '0 || sum < mind_q) begin
            mind_q <= sum;
            best_q <= c_q;
          end
          c_q   <= c_q + 1'b1;
          d_q   <= '0;
          acc_q <= '0;
        end else begin
          d_q   <= d_q + 1'b1;
          acc_q <= sum;
        end
      end
      S_PCHK: begin
        if (32'(pt_ext) >= MAX_POINTS) begin
          oldc_q  <= best_q;
          moved_q <= 1'b0;
        end else begin
          oldc_q  <= pdata_q;
          moved_q <= (pdata_q != best_q);
        end
        phase_q <= 1'b0;
        d_q     <= '0;
      end
      S_UINI: begin
        mu_q   <= cdata_q;
        neg_q  <= diff[32];
        quot_q <= diff[32] ? 33'(-diff) : 33'(diff);
        rem_q  <= '0;
        iter_q <= 6'd33;
        if (phase_q && divisor == '0) begin
          d_q <= d_q + 1'b1;
        end
      end
      S_UDIV: begin
        if (iter_q != 6'd0) begin
          iter_q <= iter_q - 1'b1;
          if (shifted >= 12'(divisor)) begin
            rem_q  <= 11'(shifted - 12'(divisor));
            quot_q <= {quot_q[31:0], 1'b1};
          end else begin
            rem_q  <= shifted[10:0];
            quot_q <= {quot_q[31:0], 1'b0};
          end
        end else if (d_q == nd_m1) begin
          d_q     <= '0;
          phase_q <= 1'b1;
        end else begin
          d_q <= d_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
      new_cluster_o  <= 3'(best_q);
      old_cluster_o  <= 3'(oldc_q);
      moved_o        <= moved_q;
      min_distance_o <= mind_q;
    end
  end

endmodule

// ===== verif/online_kmeans_update_core_tb.sv =====
// Self-checking testbench for the online k-means update core.
`timescale 1ns / 1ps
module online_kmeans_update_core_tb;
  import okmu_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         point_index;
    logic [2:0]         cluster_index;
    logic [3:0]         dim_index;
    logic signed [31:0] value;
    logic               last;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  new_cluster;
    logic [2:0]  old_cluster;
    logic        moved;
    logic [63:0] min_distance;
  } assign_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type_i = '0;
  logic [9:0] point_index_i = '0;
  logic [2:0] cluster_index_i = '0;
  logic [3:0] dim_index_i = '0;
  logic signed [31:0] value_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] new_cluster_o;
  logic [2:0] old_cluster_o;
  logic moved_o;
  logic [63:0] min_distance_o;

  online_kmeans_update_core uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [31:0] centroid_mem [MaxClusters*MaxDims];
  logic [CountW-1:0]  member_count [MaxClusters];
  logic [2:0]         member_of    [MaxPoints];
  logic signed [31:0] feature_buf  [MaxDims];
  logic [3:0]         num_clusters_q;
  logic [4:0]         num_dims_q;

  req_word_t    pending_words[$];
  assign_word_t expected_assign[$];
  bit           point_known[MaxPoints];
  int           acc_cnt = 0;
  int           iss_cnt = 0;
  int           res_cnt = 0;
  int           err_cnt = 0;
  int           quiet_cycles = 0;
  bit           no_idle = 1'b0;
  int           gen_dims;

  function automatic int eff_clusters();
    if (num_clusters_q == 0) return 1;
    return (num_clusters_q > MaxClusters) ? MaxClusters : int'(num_clusters_q);
  endfunction

  function automatic int eff_dims();
    if (num_dims_q == 0) return 1;
    return (num_dims_q > MaxDims) ? MaxDims : int'(num_dims_q);
  endfunction

  function automatic logic [63:0] sq_distance(int c, int nd);
    logic [64:0] sum;
    logic [63:0] sq;
    longint diff;
    longint ad;
    sum = '0;
    for (int d = 0; d < nd; d++) begin
      diff = longint'(centroid_mem[c*MaxDims+d]) - longint'(feature_buf[d]);
      ad = diff < 0 ? -diff : diff;
      if (ad >= 64'h1_0000_0000) sq = '1;
      else sq = ad * ad;
      sum = sum + sq;
      if (sum[64]) sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return sum[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_assign(req_word_t w);
    int nc, nd, best, oldc;
    logic [63:0] mind, dd;
    longint q;
    assign_word_t r;
    if (w.req_type == ReqLoadCentroid) begin
      centroid_mem[w.cluster_index*MaxDims+w.dim_index] = w.value;
      return;
    end
    if (w.req_type == ReqSetCluster) begin
      member_of[w.point_index] = w.cluster_index;
      if (member_count[w.cluster_index] != CountMax)
        member_count[w.cluster_index]++;
      return;
    end
    if (w.req_type != ReqFeature) return;
    feature_buf[w.dim_index] = w.value;
    if (!w.last) return;
    nc = eff_clusters();
    nd = eff_dims();
    best = 0;
    mind = sq_distance(0, nd);
    for (int c = 1; c < nc; c++) begin
      dd = sq_distance(c, nd);
      if (dd < mind) begin
        mind = dd;
        best = c;
      end
    end
    oldc = member_of[w.point_index];
    r.moved = 1'b0;
    if (oldc != best) begin
      r.moved = 1'b1;
      if (member_count[best] != CountMax) member_count[best]++;
      if (member_count[oldc] != 0) member_count[oldc]--;
      for (int d = 0; d < nd; d++) begin
        q = (longint'(feature_buf[d]) - longint'(centroid_mem[best*MaxDims+d])) /
            longint'(member_count[best]);
        centroid_mem[best*MaxDims+d] = sat32(longint'(centroid_mem[best*MaxDims+d]) + q);
      end
      for (int d = 0; d < nd; d++) begin
        if (member_count[oldc] != 0) begin
          q = (longint'(feature_buf[d]) - longint'(centroid_mem[oldc*MaxDims+d])) /
              longint'(member_count[oldc]);
          centroid_mem[oldc*MaxDims+d] =
              sat32(longint'(centroid_mem[oldc*MaxDims+d]) - q);
        end else begin
          centroid_mem[oldc*MaxDims+d] = '0;
        end
      end
      member_of[w.point_index] = best[2:0];
    end
    r.new_cluster = best[2:0];
    r.old_cluster = oldc[2:0];
    r.min_distance = mind;
    expected_assign.push_back(r);
  endtask

  // Input side: prediction at acceptance, driving at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_assign('{req_type_i, point_index_i, cluster_index_i, dim_index_i,
                       value_i, last_i});
      acc_cnt <= acc_cnt + 1;
    end
  end

  always @(negedge clk_i) begin
    req_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && acc_cnt != iss_cnt) begin
      // Hold the word until it is taken.
    end else if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 25)) begin
      w = pending_words.pop_front();
      req_type_i <= w.req_type;
      point_index_i <= w.point_index;
      cluster_index_i <= w.cluster_index;
      dim_index_i <= w.dim_index;
      value_i <= w.value;
      last_i <= w.last;
      in_valid_i <= 1'b1;
      iss_cnt <= iss_cnt + 1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output side.
  always @(negedge clk_i) begin
    int hold_cnt;
    bit hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt = 0;
      hold_done = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && res_cnt >= 40) begin
      // One long receiver stall so the core backs up onto its input.
      hold_done = 1'b1;
      hold_cnt = 600;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || $urandom_range(99) >= 25;
    end
  end

  always @(posedge clk_i) begin
    assign_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_cnt <= res_cnt + 1;
      if (expected_assign.size() == 0) begin
        $error("unexpected result word: new_cluster %0d", new_cluster_o);
        err_cnt++;
      end else begin
        e = expected_assign.pop_front();
        if (new_cluster_o !== e.new_cluster) begin
          $error("new_cluster: expected %0d, actual %0d", e.new_cluster, new_cluster_o);
          err_cnt++;
        end
        if (old_cluster_o !== e.old_cluster) begin
          $error("old_cluster: expected %0d, actual %0d", e.old_cluster, old_cluster_o);
          err_cnt++;
        end
        if (moved_o !== e.moved) begin
          $error("moved: expected %0d, actual %0d", e.moved, moved_o);
          err_cnt++;
        end
        if (min_distance_o !== e.min_distance) begin
          $error("min_distance: expected %h, actual %h", e.min_distance, min_distance_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_word_t mk_word(logic [1:0] t, logic [9:0] p, logic [2:0] c,
                                        logic [3:0] d, logic [31:0] v, logic l);
    req_word_t w;
    w.req_type = t;
    w.point_index = p;
    w.cluster_index = c;
    w.dim_index = d;
    w.value = v;
    w.last = l;
    return w;
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
  endfunction

  function automatic logic [9:0] rand_known_point();
    logic [9:0] p;
    p = $urandom;
    if (!point_known[p]) p = $urandom_range(63);
    return p;
  endfunction

  task automatic push_word(req_word_t w);
    if (w.req_type == ReqSetCluster) point_known[w.point_index] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || acc_cnt != iss_cnt || expected_assign.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CfgNumClusters) num_clusters_q = data[3:0];
    else num_dims_q = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [4:0] nc, logic [4:0] nd, int n_words);
    int cnt;
    int pick;
    logic [9:0] p;
    wait_idle();
    write_cfg(CfgNumClusters, nc);
    write_cfg(CfgNumDims, nd);
    gen_dims = eff_dims();
    cnt = 0;
    while (cnt < n_words) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        p = rand_known_point();
        for (int d = 0; d < gen_dims; d++)
          push_word(mk_word(ReqFeature, p, $urandom, d, rand_value(), d == gen_dims-1));
        cnt += gen_dims;
      end else begin
        if (pick < 72)
          push_word(mk_word(ReqLoadCentroid, $urandom, $urandom, $urandom, rand_value(), $urandom));
        else if (pick < 80)
          push_word(mk_word(ReqSetCluster, $urandom, $urandom, $urandom, $urandom, $urandom));
        else if (pick < 88)
          push_word(mk_word(ReqFeature, $urandom, $urandom, $urandom, rand_value(), 1'b0));
        else if (pick < 93)
          push_word(mk_word(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom));
        else
          push_word(mk_word(ReqFeature, rand_known_point(), $urandom, $urandom,
                            rand_value(), 1'b1));
        cnt++;
      end
    end
  endtask

  initial begin
    num_clusters_q = NumClustersReset;
    num_dims_q = NumDimsReset;
    for (int i = 0; i < MaxClusters; i++) member_count[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill every centroid element, the feature buffer and a pool of points.
    for (int c = 0; c < MaxClusters; c++)
      for (int d = 0; d < MaxDims; d++)
        push_word(mk_word(ReqLoadCentroid, 0, c, d, (c * 32'h0001_0000) - d, 1'b0));
    for (int p = 0; p < 64; p++)
      push_word(mk_word(ReqSetCluster, p, p % MaxClusters, 0, 0, 1'b0));
    for (int d = 0; d < MaxDims; d++)
      push_word(mk_word(ReqFeature, 0, 0, d, 0, d == MaxDims-1));

    // Directed words under the reset configuration.
    push_word(mk_word(ReqLoadCentroid, 0, 0, 0, 32'sh7FFF_FFFF, 1'b0));
    push_word(mk_word(ReqLoadCentroid, 0, 0, 1, 32'sh7FFF_FFFF, 1'b0));
    push_word(mk_word(ReqLoadCentroid, 0, 1, 0, 32'sh7FFF_FFFF, 1'b0));
    push_word(mk_word(ReqLoadCentroid, 0, 1, 1, 32'sh7FFF_FFFF, 1'b0));
    push_word(mk_word(ReqLoadCentroid, 0, 2, 0, 32'sh7FFF_FFFF, 1'b0));
    push_word(mk_word(ReqLoadCentroid, 0, 2, 1, 32'sh7FFF_FFFF, 1'b0));
    // The sum of two near-maximal squares saturates; all three clusters tie.
    push_word(mk_word(ReqFeature, 5, 0, 0, 32'sh8000_0000, 1'b0));
    push_word(mk_word(ReqFeature, 5, 0, 1, 32'sh8000_0000, 1'b1));
    // A point set to cluster 7 lies outside the searched clusters and must move.
    push_word(mk_word(ReqSetCluster, 10'd1023, 3'd7, 0, 0, 1'b0));
    push_word(mk_word(ReqFeature, 10'd1023, 0, 0, 32'sh0000_0001, 1'b0));
    push_word(mk_word(ReqFeature, 10'd1023, 0, 1, 32'sh0000_0000, 1'b1));
    push_word(mk_word(2'd3, 10'h3FF, 3'd7, 4'hF, 32'hFFFF_FFFF, 1'b1));
    push_word(mk_word(ReqFeature, 10'h3FF, 7, 4'hF, 32'h1234_5678, 1'b0));
    push_word(mk_word(ReqFeature, 10'd1023, 0, 4'hF, 32'sh7FFF_FFFF, 1'b1));
    push_word(mk_word(ReqFeature, 10'd1023, 0, 1, 32'sh7FFF_FFFF, 1'b1));

    run_phase(5'd1, 5'd1, 150);
    run_phase(5'd8, 5'd16, 40);
    run_phase(5'd0, 5'd0, 150);
    run_phase(5'd15, 5'd31, 40);
    run_phase(5'd2, 5'd3, 250);
    no_idle = 1'b1;
    run_phase(5'd4, 5'd2, 250);
    wait_idle();
    no_idle = 1'b0;
    run_phase(5'd8, 5'd4, 200);
    run_phase(5'd5, 5'd1, 150);
    run_phase(5'd3, 5'd17, 40);
    run_phase(5'd9, 5'd5, 150);
    run_phase(5'd6, 5'd2, 150);
    run_phase(5'd3, 5'd2, 150);

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && expected_assign.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
